FILE: src/dnapm_pkg.sv
`default_nettype none

package dnapm_pkg;

  // item commands
  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_SUBJECT = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MATCH   = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_NONBASE = 3'd3;
  localparam logic [2:0] ST_LENGTH  = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_REFUSED = 3'd6;

  // configuration register indexes and reset values
  localparam logic        CFG_WIDTH    = 1'b0;
  localparam logic        CFG_CODES    = 1'b1;
  localparam logic [5:0]  WIDTH_RESET  = 6'd8;
  localparam logic [31:0] CODES_RESET  = 32'd1414022977;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_INIT,
    OP_RESTART,
    OP_LOAD_RD,
    OP_LOAD_ADV,
    OP_PAT_RD_L,
    OP_SUBJ,
    OP_G_RD,
    OP_G_RES,
    OP_G_FOLLOW,
    OP_G_FAIL0,
    OP_G_PUSH,
    OP_W_NEXT,
    OP_C_RD,
    OP_C_WR,
    OP_POP,
    OP_TOP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       emit;
    logic [2:0] st;
    logic       load_end;
    logic       pat_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] item_cmd;
    logic       init_last;
    logic       ch_valid;
    logic       cur_zero;
    logic       fl_valid;
    logic       len_zero;
    logic       sp_zero;
    logic       walk_last;
    logic       scanning;
    logic       pat_bad;
    logic       pnum_bad;
    logic       slot_bad;
    logic       pos_ge_w;
    logic       pos_eq_w;
    logic       last;
    logic       full;
    logic       pat_nz;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/dnapm_ctrl.sv
`default_nettype none

module dnapm_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_take_i,
  output logic                 in_ready_o,
  input  dnapm_pkg::dp_stat_t  stat_i,
  output dnapm_pkg::dp_cmd_t   cmd_o
);
  import dnapm_pkg::*;

  localparam logic [4:0] S_INIT_RST = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_DEC      = 5'd2;
  localparam logic [4:0] S_INIT_CLR = 5'd3;
  localparam logic [4:0] S_L_EV     = 5'd4;
  localparam logic [4:0] S_INIT_NEW = 5'd5;
  localparam logic [4:0] S_L_CHK    = 5'd6;
  localparam logic [4:0] S_L_PAT    = 5'd7;
  localparam logic [4:0] S_G_RD     = 5'd8;
  localparam logic [4:0] S_G_EV     = 5'd9;
  localparam logic [4:0] S_W_NEXT   = 5'd10;
  localparam logic [4:0] S_C_RD     = 5'd11;
  localparam logic [4:0] S_C_WR     = 5'd12;
  localparam logic [4:0] S_POP      = 5'd13;
  localparam logic [4:0] S_TOP      = 5'd14;
  localparam logic [4:0] S_S_PAT    = 5'd15;
  localparam logic [4:0] S_EMIT     = 5'd16;

  logic [4:0] state_q, state_d;
  logic [2:0] st_q, st_d;
  logic       le_q, le_d;
  logic       pw_q, pw_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    st_d = st_q;
    le_d = le_q;
    pw_d = pw_q;
    in_ready_o = 1'b0;
    cmd_o = '{op: OP_NONE, emit: 1'b0, st: ST_OK, load_end: 1'b0, pat_wr: 1'b0};
    case (state_q)
      S_INIT_RST: begin
        cmd_o.op = OP_INIT;
        if (stat_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_take_i) state_d = S_DEC;
      end
      S_DEC: begin
        st_d = ST_OK;
        le_d = 1'b0;
        pw_d = 1'b0;
        case (stat_i.item_cmd)
          CMD_CLEAR: begin
            cmd_o.op = OP_CLEAR;
            state_d = S_INIT_CLR;
          end
          CMD_LOAD: begin
            state_d = S_EMIT;
            le_d = 1'b1;
            if (stat_i.scanning) begin
              st_d = ST_REFUSED;
              le_d = 1'b0;
            end else if (stat_i.pat_bad) begin
              st_d = ST_OK;
            end else if (stat_i.pnum_bad) begin
              st_d = ST_REFUSED;
            end else if (stat_i.slot_bad) begin
              st_d = ST_NONBASE;
            end else if (stat_i.pos_ge_w) begin
              st_d = ST_LENGTH;
            end else begin
              cmd_o.op = OP_LOAD_RD;
              state_d = S_L_EV;
            end
          end
          CMD_SUBJECT: begin
            cmd_o.op = OP_SUBJ;
            if (stat_i.slot_bad) begin
              st_d = ST_NONBASE;
              state_d = S_EMIT;
            end else begin
              state_d = S_G_RD;
            end
          end
          default: begin
            cmd_o.op = OP_RESTART;
            state_d = S_EMIT;
          end
        endcase
      end
      S_INIT_CLR: begin
        cmd_o.op = OP_INIT;
        if (stat_i.init_last) state_d = S_EMIT;
      end
      S_L_EV: begin
        if (stat_i.ch_valid) begin
          cmd_o.op = OP_LOAD_ADV;
          state_d = S_L_CHK;
        end else if (stat_i.full) begin
          st_d = ST_FULL;
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_LOAD_ADV;
          state_d = S_INIT_NEW;
        end
      end
      S_INIT_NEW: begin
        cmd_o.op = OP_INIT;
        if (stat_i.init_last) state_d = S_L_CHK;
      end
      S_L_CHK: begin
        if (!stat_i.last) begin
          state_d = S_EMIT;
        end else if (!stat_i.pos_eq_w) begin
          st_d = ST_LENGTH;
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_PAT_RD_L;
          state_d = S_L_PAT;
        end
      end
      S_L_PAT: begin
        if (stat_i.pat_nz) st_d = ST_DUP;
        else pw_d = 1'b1;
        state_d = S_EMIT;
      end
      S_G_RD: begin
        cmd_o.op = OP_G_RD;
        state_d = S_G_EV;
      end
      // resolve one step of the goto loop
      S_G_EV: begin
        if (stat_i.ch_valid || stat_i.cur_zero) begin
          cmd_o.op = OP_G_RES;
          state_d = S_C_RD;
        end else if (stat_i.fl_valid) begin
          cmd_o.op = OP_G_FOLLOW;
          state_d = S_G_RD;
        end else if (stat_i.len_zero) begin
          cmd_o.op = OP_G_FAIL0;
          state_d = S_G_RD;
        end else begin
          cmd_o.op = OP_G_PUSH;
          state_d = S_W_NEXT;
        end
      end
      S_W_NEXT: begin
        cmd_o.op = OP_W_NEXT;
        state_d = S_G_RD;
      end
      S_C_RD: begin
        cmd_o.op = OP_C_RD;
        state_d = S_C_WR;
      end
      S_C_WR: begin
        cmd_o.op = OP_C_WR;
        if (stat_i.sp_zero) state_d = S_TOP;
        else if (stat_i.walk_last) state_d = S_POP;
        else state_d = S_W_NEXT;
      end
      S_POP: begin
        cmd_o.op = OP_POP;
        state_d = S_G_RD;
      end
      S_TOP: begin
        cmd_o.op = OP_TOP;
        state_d = S_S_PAT;
      end
      S_S_PAT: begin
        st_d = stat_i.pat_nz ? ST_MATCH : ST_OK;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.st = st_q;
          cmd_o.load_end = le_q;
          cmd_o.pat_wr = pw_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT_RST;
      st_q <= ST_OK;
      le_q <= 1'b0;
      pw_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q <= st_d;
      le_q <= le_d;
      pw_q <= pw_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/dnapm_dp.sv
`default_nettype none

module dnapm_dp #(
  parameter int MAX_NODES    = 4096,
  parameter int MAX_WIDTH    = 32,
  parameter int MAX_PATTERNS = 1024
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_index_i,
  input  wire  [31:0]          cfg_data_i,
  input  wire                  in_take_i,
  input  wire  [1:0]           in_cmd_i,
  input  wire  [7:0]           in_letter_i,
  input  wire  [10:0]          in_pnum_i,
  input  wire                  in_last_i,
  input  dnapm_pkg::dp_cmd_t   cmd_i,
  output dnapm_pkg::dp_stat_t  stat_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [2:0]           out_status_o,
  output logic [10:0]          out_id_o,
  output logic [31:0]          out_pos_o
);
  import dnapm_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = NW + 1;
  localparam int HW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DW  = $clog2(MAX_WIDTH + 1);
  localparam int SPW = $clog2(MAX_WIDTH + 1);
  localparam int FW  = 3 * NW + 2 + 4 * HW;

  // configuration and latched item
  logic [5:0]  pw_q, pw_d;
  logic [31:0] codes_q, codes_d;
  logic [1:0]  it_cmd_q;
  logic [7:0]  it_letter_q;
  logic [10:0] it_pnum_q;
  logic        it_last_q;

  // matcher state
  logic [CW-1:0] node_cnt_q, node_cnt_d;
  logic [NW-1:0] load_node_q, load_node_d;
  logic [DW-1:0] load_pos_q, load_pos_d;
  logic          bad_q, bad_d;
  logic [NW-1:0] cur_node_q, cur_node_d;
  logic [31:0]   subpos_q, subpos_d;
  logic [HW-1:0] head_q, head_d;
  logic          scan_q, scan_d;
  logic [NW-1:0] init_node_q, init_node_d;
  logic [DW-1:0] init_depth_q, init_depth_d;
  logic [1:0]    init_cnt_q, init_cnt_d;
  logic [SPW-1:0] sp_q, sp_d;

  // goto frame and enclosing walk frame
  logic [NW-1:0] g_node_q, g_node_d;
  logic [1:0]    g_slot_q, g_slot_d;
  logic [HW-1:0] g_t_q, g_t_d;
  logic [NW-1:0] g_cur_q, g_cur_d;
  logic [NW-1:0] res_q, res_d;
  logic [HW-1:0] w_start_q, w_start_d;
  logic [HW-1:0] w_len_q, w_len_d;
  logic [HW-1:0] w_i_q, w_i_d;
  logic [NW-1:0] w_n_q, w_n_d;

  // output register
  logic        ov_q, ov_d;
  logic [2:0]  os_q, os_d;
  logic [10:0] oid_q, oid_d;
  logic [31:0] opos_q, opos_d;

  // memories
  logic [NW:0]   child_mem [MAX_NODES * 4];
  logic [NW:0]   fail_mem  [MAX_NODES];
  logic [DW-1:0] depth_mem [MAX_NODES];
  logic [10:0]   pat_mem   [MAX_NODES];
  logic [FW-1:0] stack_mem [MAX_WIDTH];
  logic [1:0]    hist_q    [MAX_WIDTH];

  logic [NW:0]   ch_rd_q, fl_rd_q;
  logic [DW-1:0] dp_rd_q;
  logic [10:0]   pt_rd_q;
  logic [FW-1:0] stk_rd_q;

  logic          child_re, child_we, fail_re, fail_we, depth_re, depth_we;
  logic          pat_re, pat_we, stk_we, stk_re, hist_we;
  logic [NW+1:0] child_ra, child_wa;
  logic [NW:0]   child_wd, fail_wd;
  logic [NW-1:0] fail_ra, fail_wa, depth_ra, depth_wa, pat_ra, pat_wa;
  logic [DW-1:0] depth_wd;
  logic [10:0]   pat_wd;
  logic [HW-1:0] stk_wa, stk_ra;

  // derived values
  logic          slot_ok;
  logic [1:0]    slot;
  logic [DW-1:0] eff_w;
  logic [DW-1:0] dep_m1;
  logic [HW-1:0] len;
  logic [HW:0]   start_sum;
  logic [HW-1:0] start_idx;
  logic [HW:0]   idx_sum;
  logic [HW-1:0] walk_idx;
  logic [HW-1:0] head_nx;
  logic [FW-1:0] frame_w;

  logic [NW-1:0] r_node, r_cur, r_n;
  logic [1:0]    r_slot;
  logic [HW-1:0] r_t, r_start, r_len, r_i;

  assign frame_w = {g_node_q, g_slot_q, g_t_q, g_cur_q, w_start_q, w_len_q, w_i_q, w_n_q};
  assign {r_node, r_slot, r_t, r_cur, r_start, r_len, r_i, r_n} = stk_rd_q;

  // letter code lookup, lowest slot wins
  always_comb begin
    slot_ok = 1'b0;
    slot = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (codes_q[8*k +: 8] == it_letter_q) begin
        slot_ok = 1'b1;
        slot = 2'(k);
      end
    end
  end

  // effective pattern width
  always_comb begin
    if (pw_q == 6'd0) eff_w = DW'(1);
    else if (32'(pw_q) > 32'(MAX_WIDTH)) eff_w = DW'(MAX_WIDTH);
    else eff_w = DW'(pw_q);
  end

  // failure walk length and ring indexes
  always_comb begin
    dep_m1 = (dp_rd_q == '0) ? '0 : dp_rd_q - 1'b1;
    if (dep_m1 > DW'(MAX_WIDTH - 1)) dep_m1 = DW'(MAX_WIDTH - 1);
    len = HW'(dep_m1);
    start_sum = {1'b0, g_t_q} + (HW+1)'(MAX_WIDTH) - {1'b0, len};
    if (start_sum >= (HW+1)'(MAX_WIDTH)) start_sum = start_sum - (HW+1)'(MAX_WIDTH);
    start_idx = start_sum[HW-1:0];
    idx_sum = {1'b0, w_start_q} + {1'b0, w_i_q};
    if (idx_sum >= (HW+1)'(MAX_WIDTH)) idx_sum = idx_sum - (HW+1)'(MAX_WIDTH);
    walk_idx = idx_sum[HW-1:0];
    head_nx = (head_q == HW'(MAX_WIDTH - 1)) ? '0 : head_q + 1'b1;
  end

  // status to the controller
  always_comb begin
    stat_o.item_cmd  = it_cmd_q;
    stat_o.init_last = (init_cnt_q == 2'd3);
    stat_o.ch_valid  = ch_rd_q[NW];
    stat_o.cur_zero  = (g_cur_q == '0);
    stat_o.fl_valid  = fl_rd_q[NW];
    stat_o.len_zero  = (len == '0);
    stat_o.sp_zero   = (sp_q == '0);
    stat_o.walk_last = (({1'b0, w_i_q} + 1'b1) == {1'b0, w_len_q});
    stat_o.scanning  = scan_q;
    stat_o.pat_bad   = bad_q;
    stat_o.pnum_bad  = (it_pnum_q == 11'd0) || (32'(it_pnum_q) > 32'(MAX_PATTERNS));
    stat_o.slot_bad  = !slot_ok;
    stat_o.pos_ge_w  = (load_pos_q >= eff_w);
    stat_o.pos_eq_w  = (load_pos_q == eff_w);
    stat_o.last      = it_last_q;
    stat_o.full      = (node_cnt_q >= CW'(MAX_NODES));
    stat_o.pat_nz    = (pt_rd_q != 11'd0);
    stat_o.out_free  = !ov_q || out_ready_i;
  end

  // operation decode
  always_comb begin
    pw_d = pw_q;
    codes_d = codes_q;
    node_cnt_d = node_cnt_q;
    load_node_d = load_node_q;
    load_pos_d = load_pos_q;
    bad_d = bad_q;
    cur_node_d = cur_node_q;
    subpos_d = subpos_q;
    head_d = head_q;
    scan_d = scan_q;
    init_node_d = init_node_q;
    init_depth_d = init_depth_q;
    init_cnt_d = init_cnt_q;
    sp_d = sp_q;
    g_node_d = g_node_q;
    g_slot_d = g_slot_q;
    g_t_d = g_t_q;
    g_cur_d = g_cur_q;
    res_d = res_q;
    w_start_d = w_start_q;
    w_len_d = w_len_q;
    w_i_d = w_i_q;
    w_n_d = w_n_q;
    ov_d = ov_q && !out_ready_i;
    os_d = os_q;
    oid_d = oid_q;
    opos_d = opos_q;
    child_re = 1'b0; child_ra = '0;
    child_we = 1'b0; child_wa = '0; child_wd = '0;
    fail_re = 1'b0; fail_ra = '0;
    fail_we = 1'b0; fail_wa = '0; fail_wd = '0;
    depth_re = 1'b0; depth_ra = '0;
    depth_we = 1'b0; depth_wa = '0; depth_wd = '0;
    pat_re = 1'b0; pat_ra = '0;
    pat_we = 1'b0; pat_wa = '0; pat_wd = '0;
    stk_we = 1'b0; stk_wa = '0;
    stk_re = 1'b0; stk_ra = '0;
    hist_we = 1'b0;

    case (cmd_i.op)
      OP_CLEAR: begin
        node_cnt_d = CW'(1);
        load_node_d = '0;
        load_pos_d = '0;
        bad_d = 1'b0;
        cur_node_d = '0;
        subpos_d = '0;
        head_d = '0;
        scan_d = 1'b0;
        init_node_d = '0;
        init_depth_d = '0;
        init_cnt_d = 2'd0;
      end
      // one child slot per cycle, node fields with the first
      OP_INIT: begin
        child_we = 1'b1;
        child_wa = {init_node_q, init_cnt_q};
        child_wd = '0;
        if (init_cnt_q == 2'd0) begin
          fail_we = 1'b1;
          fail_wa = init_node_q;
          fail_wd = '0;
          pat_we = 1'b1;
          pat_wa = init_node_q;
          pat_wd = '0;
          depth_we = 1'b1;
          depth_wa = init_node_q;
          depth_wd = init_depth_q;
        end
        init_cnt_d = init_cnt_q + 1'b1;
      end
      OP_RESTART: begin
        cur_node_d = '0;
        subpos_d = '0;
      end
      OP_LOAD_RD: begin
        child_re = 1'b1;
        child_ra = {load_node_q, slot};
        depth_re = 1'b1;
        depth_ra = load_node_q;
      end
      OP_LOAD_ADV: begin
        load_pos_d = load_pos_q + 1'b1;
        if (ch_rd_q[NW]) begin
          load_node_d = ch_rd_q[NW-1:0];
        end else begin
          child_we = 1'b1;
          child_wa = {load_node_q, slot};
          child_wd = {1'b1, node_cnt_q[NW-1:0]};
          load_node_d = node_cnt_q[NW-1:0];
          node_cnt_d = node_cnt_q + 1'b1;
          init_node_d = node_cnt_q[NW-1:0];
          init_depth_d = dp_rd_q + 1'b1;
          init_cnt_d = 2'd0;
        end
      end
      OP_PAT_RD_L: begin
        pat_re = 1'b1;
        pat_ra = load_node_q;
      end
      OP_SUBJ: begin
        scan_d = 1'b1;
        load_node_d = '0;
        load_pos_d = '0;
        bad_d = 1'b0;
        if (subpos_q != '1) subpos_d = subpos_q + 1'b1;
        if (slot_ok) begin
          hist_we = 1'b1;
          g_node_d = cur_node_q;
          g_slot_d = slot;
          g_t_d = head_q;
          g_cur_d = cur_node_q;
          sp_d = '0;
        end else begin
          cur_node_d = '0;
        end
      end
      OP_G_RD: begin
        child_re = 1'b1;
        child_ra = {g_cur_q, g_slot_q};
        fail_re = 1'b1;
        fail_ra = g_cur_q;
        depth_re = 1'b1;
        depth_ra = g_cur_q;
      end
      OP_G_RES: begin
        res_d = ch_rd_q[NW] ? ch_rd_q[NW-1:0] : '0;
      end
      OP_G_FOLLOW: begin
        g_cur_d = fl_rd_q[NW-1:0];
      end
      OP_G_FAIL0: begin
        fail_we = 1'b1;
        fail_wa = g_cur_q;
        fail_wd = {1'b1, {NW{1'b0}}};
        g_cur_d = '0;
      end
      // save both frames, open a walk over the history
      OP_G_PUSH: begin
        stk_we = 1'b1;
        stk_wa = sp_q[HW-1:0];
        sp_d = sp_q + 1'b1;
        w_start_d = start_idx;
        w_len_d = len;
        w_i_d = '0;
        w_n_d = '0;
      end
      OP_W_NEXT: begin
        g_node_d = w_n_q;
        g_slot_d = hist_q[walk_idx];
        g_t_d = walk_idx;
        g_cur_d = w_n_q;
      end
      OP_C_RD: begin
        child_re = 1'b1;
        child_ra = {g_node_q, g_slot_q};
      end
      // cache the shortcut, advance the enclosing walk
      OP_C_WR: begin
        if (!ch_rd_q[NW]) begin
          child_we = 1'b1;
          child_wa = {g_node_q, g_slot_q};
          child_wd = {1'b1, res_q};
        end
        w_n_d = res_q;
        w_i_d = w_i_q + 1'b1;
        stk_re = 1'b1;
        stk_ra = HW'(sp_q - 1'b1);
      end
      OP_POP: begin
        sp_d = sp_q - 1'b1;
        fail_we = 1'b1;
        fail_wa = r_cur;
        fail_wd = {1'b1, w_n_q};
        g_node_d = r_node;
        g_slot_d = r_slot;
        g_t_d = r_t;
        g_cur_d = w_n_q;
        w_start_d = r_start;
        w_len_d = r_len;
        w_i_d = r_i;
        w_n_d = r_n;
      end
      OP_TOP: begin
        cur_node_d = res_q;
        head_d = head_nx;
        pat_re = 1'b1;
        pat_ra = res_q;
      end
      default: ;
    endcase

    // result out, load bookkeeping at the end of the item
    if (cmd_i.emit) begin
      ov_d = 1'b1;
      os_d = cmd_i.st;
      oid_d = (cmd_i.st == ST_DUP || cmd_i.st == ST_MATCH) ? pt_rd_q : 11'd0;
      opos_d = (it_cmd_q == CMD_SUBJECT) ? subpos_q : 32'd0;
      if (cmd_i.load_end) begin
        if (it_last_q) begin
          load_node_d = '0;
          load_pos_d = '0;
          bad_d = 1'b0;
        end else if (cmd_i.st != ST_OK) begin
          bad_d = 1'b1;
        end
      end
      if (cmd_i.pat_wr) begin
        pat_we = 1'b1;
        pat_wa = load_node_q;
        pat_wd = it_pnum_q;
      end
    end

    // configuration writes
    if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) pw_d = cfg_data_i[5:0];
      else codes_d = cfg_data_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= WIDTH_RESET;
      codes_q <= CODES_RESET;
      node_cnt_q <= CW'(1);
      load_node_q <= '0;
      load_pos_q <= '0;
      bad_q <= 1'b0;
      cur_node_q <= '0;
      subpos_q <= '0;
      head_q <= '0;
      scan_q <= 1'b0;
      init_node_q <= '0;
      init_depth_q <= '0;
      init_cnt_q <= 2'd0;
      sp_q <= '0;
      ov_q <= 1'b0;
    end else begin
      pw_q <= pw_d;
      codes_q <= codes_d;
      node_cnt_q <= node_cnt_d;
      load_node_q <= load_node_d;
      load_pos_q <= load_pos_d;
      bad_q <= bad_d;
      cur_node_q <= cur_node_d;
      subpos_q <= subpos_d;
      head_q <= head_d;
      scan_q <= scan_d;
      init_node_q <= init_node_d;
      init_depth_q <= init_depth_d;
      init_cnt_q <= init_cnt_d;
      sp_q <= sp_d;
      ov_q <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      it_cmd_q <= in_cmd_i;
      it_letter_q <= in_letter_i;
      it_pnum_q <= in_pnum_i;
      it_last_q <= in_last_i;
    end
    g_node_q <= g_node_d;
    g_slot_q <= g_slot_d;
    g_t_q <= g_t_d;
    g_cur_q <= g_cur_d;
    res_q <= res_d;
    w_start_q <= w_start_d;
    w_len_q <= w_len_d;
    w_i_q <= w_i_d;
    w_n_q <= w_n_d;
    os_q <= os_d;
    oid_q <= oid_d;
    opos_q <= opos_d;
    if (hist_we) hist_q[head_q] <= slot;
  end

  // node tables
  always_ff @(posedge clk_i) begin
    if (child_we) child_mem[child_wa] <= child_wd;
    if (child_re) ch_rd_q <= child_mem[child_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    if (fail_re) fl_rd_q <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk_i) begin
    if (depth_we) depth_mem[depth_wa] <= depth_wd;
    if (depth_re) dp_rd_q <= depth_mem[depth_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) pat_mem[pat_wa] <= pat_wd;
    if (pat_re) pt_rd_q <= pat_mem[pat_ra];
  end

  // frame stack of the nested failure walks
  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[stk_wa] <= frame_w;
    if (stk_re) stk_rd_q <= stack_mem[stk_ra];
  end

  assign out_valid_o = ov_q;
  assign out_status_o = os_q;
  assign out_id_o = oid_q;
  assign out_pos_o = opos_q;

endmodule

`default_nettype wire

FILE: src/dna_multi_pattern_matcher.sv
`default_nettype none

// Aho-Corasick matcher for DNA dictionaries of equal-width patterns over four
// programmable letter codes. Every item gives exactly one result. After reset
// the root node is set up before the first item is taken. A new trie node
// writes its four child slots, and a last pattern letter also looks up the id.
// A subject letter uses a stored child or cached shortcut where there is one;
// each failure link that is not yet known is worked out by re-walking the
// recent letters from the root, with fallback steps along known failure links,
// all through the single-port node tables. Each goto shortcut found is cached.
// A new item is taken only once the last one has put its result out; that
// result waits in an output register while the next item is taken.
module dna_multi_pattern_matcher #(
  parameter int MAX_NODES    = 4096,
  parameter int MAX_WIDTH    = 32,
  parameter int MAX_PATTERNS = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // letter, pattern_number, zero fill
  input  wire  [1:0]  s_axis_tuser,   // command
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // pattern_id, position, zero fill
  output logic [2:0]  m_axis_tuser,   // status
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [31:0] cfg_data_i
);
  import dnapm_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        in_ready;
  logic        in_take;
  logic [10:0] out_id;
  logic [31:0] out_pos;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = in_ready;
  assign in_take = s_axis_tvalid && in_ready;
  assign m_axis_tdata = {5'd0, out_pos, out_id};

  dnapm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_take_i  (in_take),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dnapm_dp #(
    .MAX_NODES    (MAX_NODES),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_PATTERNS (MAX_PATTERNS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_take_i    (in_take),
    .in_cmd_i     (s_axis_tuser),
    .in_letter_i  (s_axis_tdata[7:0]),
    .in_pnum_i    (s_axis_tdata[18:8]),
    .in_last_i    (s_axis_tlast),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_id_o     (out_id),
    .out_pos_o    (out_pos)
  );

endmodule

`default_nettype wire
